// ----- rtl/core/slce_pkg.sv -----
// Types and constants shared by the serial load command engine modules.
package slce_pkg;

    // Fixed header geometry: three big-endian 32-bit words.
    localparam int HEADER_BYTES = 12;
    localparam int STORE_DEPTH  = HEADER_BYTES - 1;
    localparam int COUNT_WIDTH  = 4;

    // Command codes carried in the first header word.
    localparam logic [31:0] CMD_WRITE = 32'd1;
    localparam logic [31:0] CMD_READ  = 32'd2;
    localparam logic [31:0] CMD_BOOT  = 32'd3;

    // Byte returned to the host for every byte written to memory.
    localparam logic [7:0] ACK_BYTE = 8'h00;

    // Engine modes as reported on mode_now.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_WRITE  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    // One input request: the handshake level and an optional received byte.
    typedef struct packed {
        logic       dsr_level;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } item_t;

    // One result request: everything the engine drives for a tick.
    typedef struct packed {
        logic        dtr_level;
        logic        clear_fifos;
        logic        tx_valid;
        logic        tx_from_memory;
        logic [7:0]  tx_byte;
        logic        mem_write;
        logic        mem_read;
        logic [31:0] mem_addr;
        logic [7:0]  mem_data;
        logic        boot_request;
        logic [1:0]  mode_now;
    } result_t;

endpackage

// ----- rtl/core/slce_in_reg.sv -----
// Input register stage that holds one accepted request for the engine.
module slce_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  slce_pkg::item_t     item_in,
    input  logic                advance,
    output logic                item_valid,
    output slce_pkg::item_t     item_out
);

    logic            valid_reg;
    logic            valid_next;
    slce_pkg::item_t item_reg;

    // The stage frees up whenever its request moves on to the engine.
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded only on an accepted request.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

// ----- rtl/core/slce_engine.sv -----
// Protocol state machine: header collection, decode, write, read and boot.
module slce_engine
#(
    parameter int ADDR_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  slce_pkg::item_t     item,
    output slce_pkg::result_t   res
);

    slce_pkg::mode_t                    mode_reg;
    slce_pkg::mode_t                    mode_next;
    logic                               dtr_reg;
    logic                               dtr_next;
    logic [slce_pkg::COUNT_WIDTH-1:0]   count_reg;
    logic [slce_pkg::COUNT_WIDTH-1:0]   count_next;
    logic [ADDR_WIDTH-1:0]              addr_reg;
    logic [ADDR_WIDTH-1:0]              addr_next;
    logic [31:0]                        left_reg;
    logic [31:0]                        left_next;
    logic [7:0]                         store_reg [slce_pkg::STORE_DEPTH];
    logic                               store_we;
    logic [31:0]                        cmd_word;
    logic [31:0]                        addr_word;
    logic [31:0]                        len_word;

    // Header words, with the byte arriving now as the last one.
    assign cmd_word  = {store_reg[0], store_reg[1], store_reg[2], store_reg[3]};
    assign addr_word = {store_reg[4], store_reg[5], store_reg[6], store_reg[7]};
    assign len_word  = {store_reg[8], store_reg[9], store_reg[10], item.rx_byte};

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= slce_pkg::MODE_IDLE;
            dtr_reg   <= 1'b0;
            count_reg <= '0;
            addr_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            dtr_reg   <= dtr_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
        end
    end

    // Header byte store; every entry is written before the decode reads it.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg] <= item.rx_byte;
        end
    end

    // Next state and result for the request being processed.
    always_comb
    begin
        mode_next  = mode_reg;
        dtr_next   = dtr_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        store_we   = 1'b0;
        res        = '0;

        if (step_en)
        begin
            priority if (mode_reg == slce_pkg::MODE_IDLE)
            begin
                // A present host flushes the buffers and opens a header.
                if (item.dsr_level)
                begin
                    res.clear_fifos = 1'b1;
                    dtr_next        = 1'b1;
                    mode_next       = slce_pkg::MODE_HEADER;
                    count_next      = '0;
                end
            end
            else if (!item.dsr_level)
            begin
                // Host gone: drop DTR and abandon the current command.
                dtr_next  = 1'b0;
                mode_next = slce_pkg::MODE_IDLE;
            end
            else if (mode_reg == slce_pkg::MODE_HEADER)
            begin
                if (item.rx_valid)
                begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = item.rx_byte;
                    if (count_reg < slce_pkg::COUNT_WIDTH'(slce_pkg::STORE_DEPTH))
                    begin
                        store_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        // Last header byte: decode the command.
                        count_next = '0;
                        mode_next  = slce_pkg::MODE_IDLE;
                        if (cmd_word == slce_pkg::CMD_WRITE ||
                            cmd_word == slce_pkg::CMD_READ)
                        begin
                            addr_next = ADDR_WIDTH'(addr_word);
                            left_next = len_word;
                            if (len_word != 32'd0)
                            begin
                                mode_next = (cmd_word == slce_pkg::CMD_WRITE) ?
                                            slce_pkg::MODE_WRITE : slce_pkg::MODE_READ;
                            end
                        end
                        else if (cmd_word == slce_pkg::CMD_BOOT)
                        begin
                            res.boot_request = 1'b1;
                            res.mem_addr     = 32'(ADDR_WIDTH'(addr_word));
                        end
                    end
                end
            end
            else
            begin
                // Data phase of a write or read command.
                if (left_reg == 32'd0)
                begin
                    mode_next = slce_pkg::MODE_IDLE;
                end
                else if (item.rx_valid)
                begin
                    res.mem_addr = 32'(addr_reg);
                    res.tx_valid = 1'b1;
                    if (mode_reg == slce_pkg::MODE_WRITE)
                    begin
                        res.mem_write = 1'b1;
                        res.mem_data  = item.rx_byte;
                        res.tx_byte   = slce_pkg::ACK_BYTE;
                    end
                    else
                    begin
                        res.mem_read       = 1'b1;
                        res.tx_from_memory = 1'b1;
                    end
                    addr_next = addr_reg + ADDR_WIDTH'(1);
                    left_next = left_reg - 32'd1;
                    if (left_reg == 32'd1)
                    begin
                        mode_next = slce_pkg::MODE_IDLE;
                    end
                end
            end
        end

        res.dtr_level = dtr_next;
        res.mode_now  = mode_next;
    end

`ifndef SYNTHESIS
    // A single tick never both writes and reads memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(res.mem_write && res.mem_read))
        else $error("memory write and read in the same tick");

    // A boot request always ends the command.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.boot_request |-> (mode_next == slce_pkg::MODE_IDLE))
        else $error("boot request without return to idle");

    // Losing the handshake while busy drops DTR and returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && mode_reg != slce_pkg::MODE_IDLE && !item.dsr_level)
        |=> (mode_reg == slce_pkg::MODE_IDLE && !dtr_reg))
        else $error("handshake loss not handled");

    // The header counter never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= slce_pkg::COUNT_WIDTH'(slce_pkg::STORE_DEPTH))
        else $error("header counter out of range");
`endif

endmodule

// ----- rtl/core/slce_out_reg.sv -----
// Result register that holds one finished request until it is taken.
module slce_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  slce_pkg::result_t   res_in,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                advance,
    output slce_pkg::result_t   res_out
);

    logic              valid_reg;
    logic              valid_next;
    slce_pkg::result_t res_reg;

    // The register can take a new result when empty or being emptied.
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload changes only when a new result is loaded.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ----- rtl/core/serial_load_command_engine_core.sv -----
// Serial load command engine: input register, protocol engine, result register.
// A request accepted into the input register passes through the engine into the result register once it has room.
// Throughput: one request per cycle; in_stall rises only with both registers full and out_stall high.
// Reset (rst_n, asynchronous, active low): idle mode, DTR low, counters and address zero.
// The header byte store is not reset; each entry is written before the decode reads it.
module serial_load_command_engine_core
#(
    parameter int ADDR_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        dsr_level,
    input  logic        rx_valid,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        dtr_level,
    output logic        clear_fifos,
    output logic        tx_valid,
    output logic        tx_from_memory,
    output logic [7:0]  tx_byte,
    output logic        mem_write,
    output logic        mem_read,
    output logic [31:0] mem_addr,
    output logic [7:0]  mem_data,
    output logic        boot_request,
    output logic [1:0]  mode_now
);

    slce_pkg::item_t   item_in;
    slce_pkg::item_t   item;
    slce_pkg::result_t res_comb;
    slce_pkg::result_t res_out;
    logic              item_valid;
    logic              advance;
    logic              step_en;

    assign item_in.dsr_level = dsr_level;
    assign item_in.rx_valid  = rx_valid;
    assign item_in.rx_byte   = rx_byte;

    // A held request is processed once the result register has room.
    assign step_en = item_valid && advance;

    slce_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item_in    (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    slce_engine
    #(
        .ADDR_WIDTH (ADDR_WIDTH)
    )
    u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item),
        .res     (res_comb)
    );

    slce_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_en),
        .res_in    (res_comb),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .advance   (advance),
        .res_out   (res_out)
    );

    // Result fields to ports.
    assign dtr_level      = res_out.dtr_level;
    assign clear_fifos    = res_out.clear_fifos;
    assign tx_valid       = res_out.tx_valid;
    assign tx_from_memory = res_out.tx_from_memory;
    assign tx_byte        = res_out.tx_byte;
    assign mem_write      = res_out.mem_write;
    assign mem_read       = res_out.mem_read;
    assign mem_addr       = res_out.mem_addr;
    assign mem_data       = res_out.mem_data;
    assign boot_request   = res_out.boot_request;
    assign mode_now       = res_out.mode_now;

endmodule
